>>> rtl/sls_pkg.sv
// shared types, opcodes and helpers for the lane shuffle unit
package sls_pkg;

	localparam logic [3:0] OP_UNPCKLPS = 4'd0;
	localparam logic [3:0] OP_UNPCKLPD = 4'd1;
	localparam logic [3:0] OP_UNPCKHPS = 4'd2;
	localparam logic [3:0] OP_UNPCKHPD = 4'd3;
	localparam logic [3:0] OP_SHUFPS   = 4'd4;
	localparam logic [3:0] OP_SHUFPD   = 4'd5;
	localparam logic [3:0] OP_PSHUFD   = 4'd6;
	localparam logic [3:0] OP_PSHUFLW  = 4'd7;
	localparam logic [3:0] OP_PSHUFHW  = 4'd8;
	localparam logic [3:0] OP_MOVSLDUP = 4'd9;
	localparam logic [3:0] OP_MOVSHDUP = 4'd10;
	localparam logic [3:0] OP_MOVDDUP  = 4'd11;

	localparam int unsigned LANE_WORDS = 8;

	// one source word: bit 3 picks the second source, bits 2:0 the word in the lane
	typedef logic [3:0] word_sel_t;

	typedef struct packed {
		logic                             zero;
		logic [LANE_WORDS-1:0][3:0]       sel;
	} perm_ctl_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [7:0]  imm_control;
		logic [1:0]  lane_index;
		logic [63:0] first_low;
		logic [63:0] first_high;
		logic [63:0] second_low;
		logic [63:0] second_high;
		logic        final_lane;
	} src_beat_t;

	typedef struct packed {
		logic [63:0] result_low;
		logic [63:0] result_high;
		logic        final_lane_out;
	} res_beat_t;

	// word selects for one 32-bit element, {high word, low word}
	function automatic logic [1:0][3:0] dword_sel(input logic src, input logic [1:0] idx);
		dword_sel = {{src, idx, 1'b1}, {src, idx, 1'b0}};
	endfunction

endpackage

>>> rtl/sls_decode.sv
// opcode and immediate decode into per-word source selects
module sls_decode (
	input  logic [3:0]        opcode,
	input  logic [7:0]        imm_control,
	input  logic [1:0]        lane_index,
	output sls_pkg::perm_ctl_t ctl
);
	import sls_pkg::*;

	logic [1:0] s0, s1, s2, s3;
	logic       pd_a, pd_b;

	assign s0 = imm_control[1:0];
	assign s1 = imm_control[3:2];
	assign s2 = imm_control[5:4];
	assign s3 = imm_control[7:6];
	// shufpd takes its two bits at the lane's own position
	assign pd_a = imm_control[{lane_index, 1'b0}];
	assign pd_b = imm_control[{lane_index, 1'b1}];

	always_comb begin
		ctl.zero = 1'b0;
		for (int i = 0; i < LANE_WORDS; i++) begin
			ctl.sel[i] = word_sel_t'(i);
		end
		unique case (opcode)
			OP_UNPCKLPS: begin
				ctl.sel[1:0] = dword_sel(1'b0, 2'd0);
				ctl.sel[3:2] = dword_sel(1'b1, 2'd0);
				ctl.sel[5:4] = dword_sel(1'b0, 2'd1);
				ctl.sel[7:6] = dword_sel(1'b1, 2'd1);
			end
			OP_UNPCKLPD: begin
				ctl.sel[1:0] = dword_sel(1'b0, 2'd0);
				ctl.sel[3:2] = dword_sel(1'b0, 2'd1);
				ctl.sel[5:4] = dword_sel(1'b1, 2'd0);
				ctl.sel[7:6] = dword_sel(1'b1, 2'd1);
			end
			OP_UNPCKHPS: begin
				ctl.sel[1:0] = dword_sel(1'b0, 2'd2);
				ctl.sel[3:2] = dword_sel(1'b1, 2'd2);
				ctl.sel[5:4] = dword_sel(1'b0, 2'd3);
				ctl.sel[7:6] = dword_sel(1'b1, 2'd3);
			end
			OP_UNPCKHPD: begin
				ctl.sel[1:0] = dword_sel(1'b0, 2'd2);
				ctl.sel[3:2] = dword_sel(1'b0, 2'd3);
				ctl.sel[5:4] = dword_sel(1'b1, 2'd2);
				ctl.sel[7:6] = dword_sel(1'b1, 2'd3);
			end
			OP_SHUFPS: begin
				ctl.sel[1:0] = dword_sel(1'b0, s0);
				ctl.sel[3:2] = dword_sel(1'b0, s1);
				ctl.sel[5:4] = dword_sel(1'b1, s2);
				ctl.sel[7:6] = dword_sel(1'b1, s3);
			end
			OP_SHUFPD: begin
				ctl.sel[1:0] = dword_sel(1'b0, {pd_a, 1'b0});
				ctl.sel[3:2] = dword_sel(1'b0, {pd_a, 1'b1});
				ctl.sel[5:4] = dword_sel(1'b1, {pd_b, 1'b0});
				ctl.sel[7:6] = dword_sel(1'b1, {pd_b, 1'b1});
			end
			OP_PSHUFD: begin
				ctl.sel[1:0] = dword_sel(1'b0, s0);
				ctl.sel[3:2] = dword_sel(1'b0, s1);
				ctl.sel[5:4] = dword_sel(1'b0, s2);
				ctl.sel[7:6] = dword_sel(1'b0, s3);
			end
			OP_PSHUFLW: begin
				ctl.sel[0] = {2'b00, s0};
				ctl.sel[1] = {2'b00, s1};
				ctl.sel[2] = {2'b00, s2};
				ctl.sel[3] = {2'b00, s3};
			end
			OP_PSHUFHW: begin
				ctl.sel[4] = {2'b01, s0};
				ctl.sel[5] = {2'b01, s1};
				ctl.sel[6] = {2'b01, s2};
				ctl.sel[7] = {2'b01, s3};
			end
			OP_MOVSLDUP: begin
				ctl.sel[1:0] = dword_sel(1'b0, 2'd0);
				ctl.sel[3:2] = dword_sel(1'b0, 2'd0);
				ctl.sel[5:4] = dword_sel(1'b0, 2'd2);
				ctl.sel[7:6] = dword_sel(1'b0, 2'd2);
			end
			OP_MOVSHDUP: begin
				ctl.sel[1:0] = dword_sel(1'b0, 2'd1);
				ctl.sel[3:2] = dword_sel(1'b0, 2'd1);
				ctl.sel[5:4] = dword_sel(1'b0, 2'd3);
				ctl.sel[7:6] = dword_sel(1'b0, 2'd3);
			end
			OP_MOVDDUP: begin
				ctl.sel[1:0] = dword_sel(1'b0, 2'd0);
				ctl.sel[3:2] = dword_sel(1'b0, 2'd1);
				ctl.sel[5:4] = dword_sel(1'b0, 2'd0);
				ctl.sel[7:6] = dword_sel(1'b0, 2'd1);
			end
			default: begin
				ctl.zero = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/simd_lane_shuffle.sv
// top level: three-stage lane permute pipeline
//
//   channel  dir  handshake               payload
//   src      in   src_valid / src_ready   sls_pkg::src_beat_t
//   res      out  res_valid / res_ready   sls_pkg::res_beat_t
//
// one beat per cycle sustained while res_ready holds
// stage 1 registers the beat, stage 2 holds decoded word selects,
// stage 3 holds the selected words and drives res
// each stage loads when it is empty or its successor moves, so bubbles close up
// a stall on res holds every full stage; reset empties the pipe
module simd_lane_shuffle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  sls_pkg::src_beat_t src,
	output logic               res_valid,
	input  logic               res_ready,
	output sls_pkg::res_beat_t res
);
	import sls_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        en_s1, en_s2, en_s3;
	src_beat_t   beat_s1;
	perm_ctl_t   ctl_dec, ctl_s2;
	logic [15:0][15:0] words_s2;
	logic        fin_s2;
	logic [15:0][15:0] words_cur;
	logic [LANE_WORDS-1:0][15:0] pick;
	res_beat_t   res_s3;

	assign en_s3 = !v_s3 || res_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign src_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= src_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: register the incoming beat
	always_ff @(posedge clk) begin
		if (en_s1 && src_valid) begin
			beat_s1 <= src;
		end
	end

	sls_decode u_decode (
		.opcode      (beat_s1.opcode),
		.imm_control (beat_s1.imm_control),
		.lane_index  (beat_s1.lane_index),
		.ctl         (ctl_dec)
	);

	// stage 2: decoded selects next to the source words
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			ctl_s2   <= ctl_dec;
			words_s2 <= {beat_s1.second_high, beat_s1.second_low,
				beat_s1.first_high, beat_s1.first_low};
			fin_s2   <= beat_s1.final_lane;
		end
	end

	// stage 3: one 16-way word mux per result word
	always_comb begin
		words_cur = words_s2;
		for (int i = 0; i < LANE_WORDS; i++) begin
			pick[i] = ctl_s2.zero ? 16'h0000 : words_cur[ctl_s2.sel[i]];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			res_s3.result_low     <= pick[3:0];
			res_s3.result_high    <= pick[7:4];
			res_s3.final_lane_out <= fin_s2;
		end
	end

	assign res_valid = v_s3;
	assign res       = res_s3;

	a_empty_out_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> src_ready)
		else $error("input stalled with empty output stage");

	a_drain_takes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> src_ready)
		else $error("input stalled while output drains");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && en_s2 |=> v_s2)
		else $error("beat lost between stage 1 and stage 2");

	a_unused_op_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en_s3 && ctl_s2.zero |=> res.result_low == 64'd0 && res.result_high == 64'd0)
		else $error("unused opcode gave nonzero result");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en_s3 |=> res_valid)
		else $error("beat lost between stage 2 and output");

endmodule
